// ----- src/block_diagonal_matrix_multiply_macros.svh -----
// Assertion macros for the block diagonal matrix multiply unit.
`ifndef BLOCK_DIAGONAL_MATRIX_MULTIPLY_MACROS_SVH
`define BLOCK_DIAGONAL_MATRIX_MULTIPLY_MACROS_SVH

`ifndef ASSERT_OFF
`define BMM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define BMM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define BMM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BMM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- src/bmm_pkg.sv -----
`timescale 1ns / 1ps

package bmm_pkg;

	localparam int MAX_DIM_DEF   = 8;
	localparam int FRAC_BITS_DEF = 16;

	localparam int ELEM_W     = 32;
	localparam int IDX_W      = 3;
	localparam int DIM_W      = 4;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = 2;
	localparam int CNT_W      = 3;

	typedef logic [DIM_W-1:0] dim_t;

	typedef enum logic [1:0] {
		ACT_LOAD_A  = 2'd0,
		ACT_LOAD_B  = 2'd1,
		ACT_COMPUTE = 2'd2
	} act_t;

	typedef enum logic [1:0] {
		MODE_FULL  = 2'd0,
		MODE_B_BLK = 2'd1,
		MODE_A_BLK = 2'd2,
		MODE_BOTH  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_ROWS_A       = 3'd0,
		REG_INNER_DIM    = 3'd1,
		REG_COLS_B       = 3'd2,
		REG_BLOCK_SIZE   = 3'd3,
		REG_PRODUCT_MODE = 3'd4
	} reg_idx_t;

	// Effective (clamped) configuration.
	typedef struct packed {
		dim_t  nr;
		dim_t  nk;
		dim_t  nc;
		dim_t  bs;
		mode_t mode;
	} cfg_t;

	// Request queued between front and back.
	typedef struct packed {
		act_t              kind;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [ELEM_W-1:0] value;
	} cmd_t;

	function automatic dim_t clamp_dim(dim_t v, dim_t lim);
		dim_t r;
		if (v == '0) begin
			r = dim_t'(1);
		end else if (v > lim) begin
			r = lim;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ----- src/block_diagonal_matrix_multiply.sv -----
`timescale 1ns / 1ps
// Block diagonal matrix multiply unit.
// Input channel (item_valid / item_stall): action 0 loads element_value into
// A(element_row, element_col), action 1 into B; loads outside the configured
// dimensions and action 3 are dropped. Action 2 computes C = A * B.
// Result channel (result_valid / result_stall): one request per element of C,
// row-major, last set on the final element. Values are Q16.16, rounded half up
// and saturated to 32 bits with the saturated flag.
// Config port (cfg_we / cfg_index / cfg_data): write only while idle.
// A four-entry request queue separates intake from execution: loads are taken
// one per cycle while the queue is not full and are written to A or B as they
// leave the queue. A compute runs one multiply-accumulate per cycle on the
// single multiplier while the result side does not stall; each C element
// issues one step per term of its k range, or a single step if that range is
// empty. Steps pass the RAM read, the product register and the accumulator,
// then the result is registered on the outputs. A stall on the result side
// freezes the whole compute pipeline; intake continues until the queue fills.
// Reset clears the configuration to 8x8x8, block size 1, full mode; A and B
// contents are undefined until loaded.

module block_diagonal_matrix_multiply #(
	parameter int MAX_DIM   = bmm_pkg::MAX_DIM_DEF,
	parameter int FRAC_BITS = bmm_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [2:0]                        cfg_index,
	input  logic [bmm_pkg::DIM_W-1:0]         cfg_data,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic [1:0]                        action,
	input  logic [bmm_pkg::IDX_W-1:0]         element_row,
	input  logic [bmm_pkg::IDX_W-1:0]         element_col,
	input  logic signed [bmm_pkg::ELEM_W-1:0] element_value,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [bmm_pkg::IDX_W-1:0]         out_row,
	output logic [bmm_pkg::IDX_W-1:0]         out_col,
	output logic signed [bmm_pkg::ELEM_W-1:0] out_value,
	output logic                              saturated,
	output logic                              last
);
	import bmm_pkg::*;

`include "block_diagonal_matrix_multiply_macros.svh"

	dim_t  rows_a_q, inner_dim_q, cols_b_q, block_size_q;
	mode_t product_mode_q;
	cfg_t  cfg;
	logic  push, full, pop, empty;
	cmd_t  cmd_in, cmd_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q       <= dim_t'(8);
			inner_dim_q    <= dim_t'(8);
			cols_b_q       <= dim_t'(8);
			block_size_q   <= dim_t'(1);
			product_mode_q <= MODE_FULL;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROWS_A:       rows_a_q       <= cfg_data;
				REG_INNER_DIM:    inner_dim_q    <= cfg_data;
				REG_COLS_B:       cols_b_q       <= cfg_data;
				REG_BLOCK_SIZE:   block_size_q   <= cfg_data;
				REG_PRODUCT_MODE: product_mode_q <= mode_t'(cfg_data[1:0]);
				default:          ;
			endcase
		end
	end

	assign cfg.nr   = clamp_dim(rows_a_q, dim_t'(MAX_DIM));
	assign cfg.nk   = clamp_dim(inner_dim_q, dim_t'(MAX_DIM));
	assign cfg.nc   = clamp_dim(cols_b_q, dim_t'(MAX_DIM));
	assign cfg.bs   = clamp_dim(block_size_q, dim_t'(MAX_DIM));
	assign cfg.mode = product_mode_q;

	bmm_front u_front (
		.cfg           (cfg),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.action        (action),
		.element_row   (element_row),
		.element_col   (element_col),
		.element_value (element_value),
		.fifo_full     (full),
		.push          (push),
		.cmd           (cmd_in)
	);

	bmm_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (cmd_in),
		.full   (full),
		.pop    (pop),
		.dout   (cmd_out),
		.empty  (empty)
	);

	bmm_back #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd_empty    (empty),
		.cmd          (cmd_out),
		.cmd_pop      (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_row      (out_row),
		.out_col      (out_col),
		.out_value    (out_value),
		.saturated    (saturated),
		.last         (last)
	);

	`BMM_ASSERT_IMP(a_sat_value, clk, arst_n, result_valid && saturated,
		out_value == 32'h7fff_ffff || out_value == 32'h8000_0000)
	`BMM_ASSERT_IMP(a_index_range, clk, arst_n, result_valid,
		dim_t'(out_row) < cfg.nr && dim_t'(out_col) < cfg.nc)
	`BMM_ASSERT_IMP(a_last_pos, clk, arst_n, result_valid && last,
		dim_t'(out_row) == cfg.nr - dim_t'(1) && dim_t'(out_col) == cfg.nc - dim_t'(1))

endmodule

// ----- src/bmm_ram.sv -----
`timescale 1ns / 1ps

module bmm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/bmm_front.sv -----
`timescale 1ns / 1ps

module bmm_front (
	input  bmm_pkg::cfg_t                  cfg,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  logic [1:0]                     action,
	input  logic [bmm_pkg::IDX_W-1:0]      element_row,
	input  logic [bmm_pkg::IDX_W-1:0]      element_col,
	input  logic signed [bmm_pkg::ELEM_W-1:0] element_value,
	input  logic                           fifo_full,
	output logic                           push,
	output bmm_pkg::cmd_t                  cmd
);
	import bmm_pkg::*;

	logic keep;
	dim_t r_ext;
	dim_t c_ext;

	assign r_ext = dim_t'(element_row);
	assign c_ext = dim_t'(element_col);

	always_comb begin
		keep = 1'b0;
		case (action)
			ACT_LOAD_A:  keep = (r_ext < cfg.nr) && (c_ext < cfg.nk);
			ACT_LOAD_B:  keep = (r_ext < cfg.nk) && (c_ext < cfg.nc);
			ACT_COMPUTE: keep = 1'b1;
			default:     keep = 1'b0;
		endcase
	end

	assign item_stall = fifo_full;
	assign push       = item_valid && !fifo_full && keep;
	assign cmd.kind   = act_t'(action);
	assign cmd.row    = element_row;
	assign cmd.col    = element_col;
	assign cmd.value  = element_value;

endmodule

// ----- src/bmm_fifo.sv -----
`timescale 1ns / 1ps

module bmm_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bmm_pkg::cmd_t din,
	output logic          full,
	input  logic          pop,
	output bmm_pkg::cmd_t dout,
	output logic          empty
);
	import bmm_pkg::*;

	cmd_t             slot_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

endmodule

// ----- src/bmm_back.sv -----
`timescale 1ns / 1ps

module bmm_back #(
	parameter int MAX_DIM   = bmm_pkg::MAX_DIM_DEF,
	parameter int FRAC_BITS = bmm_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bmm_pkg::cfg_t                     cfg,
	input  logic                              cmd_empty,
	input  bmm_pkg::cmd_t                     cmd,
	output logic                              cmd_pop,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [bmm_pkg::IDX_W-1:0]         out_row,
	output logic [bmm_pkg::IDX_W-1:0]         out_col,
	output logic signed [bmm_pkg::ELEM_W-1:0] out_value,
	output logic                              saturated,
	output logic                              last
);
	import bmm_pkg::*;

	localparam int DIM_SQ = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = (DIM_SQ > 1) ? $clog2(DIM_SQ) : 1;
	localparam int PROD_W = 2 * ELEM_W;
	localparam int ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;
	localparam logic [ACC_W-1:0] ONE_LSB = ACC_W'(1) << FRAC_BITS;
	localparam logic [ACC_W-1:0] HALF    = ONE_LSB >> 1;

	typedef enum logic {S_IDLE, S_RUN} state_t;

	typedef struct packed {
		logic             valid;
		logic             term;
		logic             first;
		logic             done;
		logic             last;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} step_t;

	state_t state_q;
	dim_t   i_q, j_q, k_q;
	dim_t   ib_start_q, ib_cnt_q, jb_start_q, jb_cnt_q;
	logic   elem_first_q;

	dim_t   from, to_raw, to, kk;
	logic   active, has_terms, step_done, last_elem, row_end;
	logic   adv, issue, start, load_a, load_b;
	step_t  step;

	logic [ADDR_W-1:0]    waddr, a_raddr, b_raddr;
	logic [ELEM_W-1:0]    a_rd, b_rd;

	step_t                    tag_s1, tag_s2, tag_s3;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  rounded, shifted;
	logic                     ovf;

	assign adv     = !(result_valid && result_stall);
	assign cmd_pop = (state_q == S_IDLE) && !cmd_empty;
	assign start   = cmd_pop && (cmd.kind == ACT_COMPUTE);
	assign load_a  = cmd_pop && (cmd.kind == ACT_LOAD_A);
	assign load_b  = cmd_pop && (cmd.kind == ACT_LOAD_B);
	assign issue   = (state_q == S_RUN) && adv;

	always_comb begin
		case (cfg.mode)
			MODE_FULL:  from = '0;
			MODE_B_BLK: from = jb_start_q;
			default:    from = ib_start_q;
		endcase
	end

	assign to_raw    = from + cfg.bs;
	assign to        = (cfg.mode == MODE_FULL || to_raw > cfg.nk) ? cfg.nk : to_raw;
	assign active    = (cfg.mode != MODE_BOTH) || (ib_start_q == jb_start_q);
	assign has_terms = active && (from < to);
	assign kk        = elem_first_q ? from : k_q;
	assign step_done = !has_terms || (kk + dim_t'(1) == to);
	assign row_end   = (j_q == cfg.nc - dim_t'(1));
	assign last_elem = row_end && (i_q == cfg.nr - dim_t'(1));

	assign step.valid = issue;
	assign step.term  = has_terms;
	assign step.first = elem_first_q;
	assign step.done  = step_done;
	assign step.last  = last_elem;
	assign step.row   = i_q[IDX_W-1:0];
	assign step.col   = j_q[IDX_W-1:0];

	// Sequencer over (i, j, k); block starts tracked by counting.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			i_q          <= '0;
			j_q          <= '0;
			k_q          <= '0;
			ib_start_q   <= '0;
			ib_cnt_q     <= '0;
			jb_start_q   <= '0;
			jb_cnt_q     <= '0;
			elem_first_q <= 1'b1;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q      <= S_RUN;
						i_q          <= '0;
						j_q          <= '0;
						ib_start_q   <= '0;
						ib_cnt_q     <= '0;
						jb_start_q   <= '0;
						jb_cnt_q     <= '0;
						elem_first_q <= 1'b1;
					end
				end
				S_RUN: begin
					if (issue) begin
						if (!step_done) begin
							k_q          <= kk + dim_t'(1);
							elem_first_q <= 1'b0;
						end else begin
							elem_first_q <= 1'b1;
							if (last_elem) begin
								state_q <= S_IDLE;
							end
							if (row_end) begin
								j_q        <= '0;
								jb_start_q <= '0;
								jb_cnt_q   <= '0;
								i_q        <= i_q + dim_t'(1);
								if (ib_cnt_q + dim_t'(1) == cfg.bs) begin
									ib_cnt_q   <= '0;
									ib_start_q <= i_q + dim_t'(1);
								end else begin
									ib_cnt_q <= ib_cnt_q + dim_t'(1);
								end
							end else begin
								j_q <= j_q + dim_t'(1);
								if (jb_cnt_q + dim_t'(1) == cfg.bs) begin
									jb_cnt_q   <= '0;
									jb_start_q <= j_q + dim_t'(1);
								end else begin
									jb_cnt_q <= jb_cnt_q + dim_t'(1);
								end
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign waddr   = ADDR_W'(int'(cmd.row) * MAX_DIM + int'(cmd.col));
	assign a_raddr = ADDR_W'(int'(i_q) * MAX_DIM + int'(kk));
	assign b_raddr = ADDR_W'(int'(kk) * MAX_DIM + int'(j_q));

	bmm_ram #(.WIDTH(ELEM_W), .DEPTH(DIM_SQ)) u_a_ram (
		.clk   (clk),
		.we    (load_a),
		.waddr (waddr),
		.wdata (cmd.value),
		.re    (issue),
		.raddr (a_raddr),
		.rdata (a_rd)
	);

	bmm_ram #(.WIDTH(ELEM_W), .DEPTH(DIM_SQ)) u_b_ram (
		.clk   (clk),
		.we    (load_b),
		.waddr (waddr),
		.wdata (cmd.value),
		.re    (issue),
		.raddr (b_raddr),
		.rdata (b_rd)
	);

	// Round half up, then saturate to 32 bits.
	assign rounded = acc_q + $signed(HALF);
	assign shifted = rounded >>> FRAC_BITS;
	assign ovf     = !((&shifted[ACC_W-1:ELEM_W-1]) || !(|shifted[ACC_W-1:ELEM_W-1]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1       <= '0;
			tag_s2       <= '0;
			tag_s3       <= '0;
			result_valid <= 1'b0;
		end else if (adv) begin
			tag_s1       <= step;
			tag_s2       <= tag_s1;
			tag_s3       <= tag_s2;
			result_valid <= tag_s3.valid && tag_s3.done;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (tag_s1.term) begin
				prod_s2 <= $signed(a_rd) * $signed(b_rd);
			end else begin
				prod_s2 <= '0;
			end
			if (tag_s2.valid) begin
				acc_q <= (tag_s2.first ? '0 : acc_q)
					+ {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
			end
			out_row   <= tag_s3.row;
			out_col   <= tag_s3.col;
			last      <= tag_s3.last;
			saturated <= ovf;
			if (ovf) begin
				out_value <= shifted[ACC_W-1] ? {1'b1, {(ELEM_W-1){1'b0}}}
					: {1'b0, {(ELEM_W-1){1'b1}}};
			end else begin
				out_value <= shifted[ELEM_W-1:0];
			end
		end
	end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import bmm_pkg::*;

	localparam int SETTLE_CYCLES = 24;
	localparam int STUCK_LIMIT   = 4000;
	localparam int RANDOM_ITEMS  = 200;
	localparam int STEADY_ITEMS  = 40;
	localparam int HOLD_CYCLES   = 300;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam logic [2:0] REG_SPARE_LO = 3'd5;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	localparam logic signed [79:0] ROUND_HALF = 80'sd1 <<< (FRAC_BITS_DEF - 1);
	localparam logic signed [79:0] SUM_MAX = 80'sh7FFFFFFF;
	localparam logic signed [79:0] SUM_MIN = -80'sh80000000;

	typedef struct packed {
		logic [IDX_W-1:0]         row;
		logic [IDX_W-1:0]         col;
		logic signed [ELEM_W-1:0] value;
		logic                     sat;
		logic                     last;
	} c_elem_t;

	logic                     clk;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [2:0]               cfg_index = '0;
	logic [DIM_W-1:0]         cfg_data = '0;
	logic                     item_valid = 1'b0;
	logic                     item_stall;
	logic [1:0]               action = '0;
	logic [IDX_W-1:0]         element_row = '0;
	logic [IDX_W-1:0]         element_col = '0;
	logic signed [ELEM_W-1:0] element_value = '0;
	logic                     result_valid;
	logic                     result_stall = 1'b0;
	logic [IDX_W-1:0]         out_row;
	logic [IDX_W-1:0]         out_col;
	logic signed [ELEM_W-1:0] out_value;
	logic                     saturated;
	logic                     last;

	block_diagonal_matrix_multiply dut (.*);

	// predictor state
	logic signed [ELEM_W-1:0] a_mem [MAX_DIM_DEF*MAX_DIM_DEF];
	logic signed [ELEM_W-1:0] b_mem [MAX_DIM_DEF*MAX_DIM_DEF];
	bit a_written [MAX_DIM_DEF*MAX_DIM_DEF];
	bit b_written [MAX_DIM_DEF*MAX_DIM_DEF];
	logic [DIM_W-1:0] cfg_rows = 4'd8;
	logic [DIM_W-1:0] cfg_inner = 4'd8;
	logic [DIM_W-1:0] cfg_cols = 4'd8;
	logic [DIM_W-1:0] cfg_block = 4'd1;
	logic [1:0]       cfg_mode = MODE_FULL;

	c_elem_t product_q [$];

	bit idle_en = 1'b1;
	int hold_request = 0;
	int mismatches = 0;
	int effective_items = 0;
	int n_loads = 0;
	int n_computes = 0;
	int n_results = 0;
	int n_settings = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int eff_dim(logic [DIM_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_DIM_DEF)
			return MAX_DIM_DEF;
		return int'(v);
	endfunction

	function automatic logic [ELEM_W-1:0] rand_elem();
		case ($urandom_range(0, 9))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return '0;
			3, 4: return $urandom;
			default: return 32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000);
		endcase
	endfunction

	function automatic logic [DIM_W-1:0] pick_dim();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 4'($urandom_range(9, 15));
			2: return 4'd8;
			default: return 4'($urandom_range(1, 4));
		endcase
	endfunction

	function automatic void predict_product();
		int nr, nk, nc, bs, i, j, k, lo, hi;
		bit active;
		logic signed [79:0] acc, pa, pb;
		c_elem_t e;
		nr = eff_dim(cfg_rows);
		nk = eff_dim(cfg_inner);
		nc = eff_dim(cfg_cols);
		bs = eff_dim(cfg_block);
		for (i = 0; i < nr; i++) begin
			for (j = 0; j < nc; j++) begin
				lo = 0;
				hi = nk;
				active = 1'b1;
				case (cfg_mode)
					MODE_B_BLK: lo = bs * (j / bs);
					MODE_A_BLK: lo = bs * (i / bs);
					MODE_BOTH: begin
						lo = bs * (i / bs);
						active = (j / bs) == (i / bs);
					end
					default: ;
				endcase
				if (cfg_mode != MODE_FULL) begin
					hi = lo + bs;
					if (hi > nk)
						hi = nk;
				end
				e.value = '0;
				e.sat = 1'b0;
				if (active) begin
					acc = '0;
					for (k = lo; k < hi; k++) begin
						pa = a_mem[i*MAX_DIM_DEF + k];
						pb = b_mem[k*MAX_DIM_DEF + j];
						acc = acc + pa * pb;
					end
					acc = (acc + ROUND_HALF) >>> FRAC_BITS_DEF;
					if (acc > SUM_MAX) begin
						e.value = 32'h7FFFFFFF;
						e.sat = 1'b1;
					end else if (acc < SUM_MIN) begin
						e.value = 32'h80000000;
						e.sat = 1'b1;
					end else begin
						e.value = acc[31:0];
					end
				end
				e.row = 3'(i);
				e.col = 3'(j);
				e.last = (i == nr - 1) && (j == nc - 1);
				product_q.push_back(e);
			end
		end
	endfunction

	function automatic void apply_request(logic [1:0] act, logic [2:0] r, logic [2:0] c,
			logic [ELEM_W-1:0] v);
		int nr, nk, nc;
		nr = eff_dim(cfg_rows);
		nk = eff_dim(cfg_inner);
		nc = eff_dim(cfg_cols);
		case (act)
			ACT_LOAD_A: if (r < nr && c < nk) begin
				a_mem[r*MAX_DIM_DEF + c] = v;
				a_written[r*MAX_DIM_DEF + c] = 1'b1;
				effective_items++;
				n_loads++;
			end
			ACT_LOAD_B: if (r < nk && c < nc) begin
				b_mem[r*MAX_DIM_DEF + c] = v;
				b_written[r*MAX_DIM_DEF + c] = 1'b1;
				effective_items++;
				n_loads++;
			end
			ACT_COMPUTE: begin
				predict_product();
				effective_items++;
				n_computes++;
			end
			default: ;
		endcase
	endfunction

	// one input request; valid stays up afterwards until the next gap or hold_input
	task automatic send_item(logic [1:0] act, logic [2:0] r, logic [2:0] c,
			logic [ELEM_W-1:0] v);
		int gap;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		action <= act;
		element_row <= r;
		element_col <= c;
		element_value <= v;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		apply_request(act, r, c, v);
	endtask

	task automatic hold_input();
		item_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		hold_input();
		@(posedge clk);
		while (product_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_put(logic [2:0] idx, logic [DIM_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_ROWS_A: cfg_rows = data;
			REG_INNER_DIM: cfg_inner = data;
			REG_COLS_B: cfg_cols = data;
			REG_BLOCK_SIZE: cfg_block = data;
			REG_PRODUCT_MODE: cfg_mode = data[1:0];
			default: ;
		endcase
	endtask

	task automatic write_config(logic [DIM_W-1:0] rows, logic [DIM_W-1:0] inner,
			logic [DIM_W-1:0] cols, logic [DIM_W-1:0] bsize, logic [1:0] mode);
		cfg_put(REG_ROWS_A, rows);
		cfg_put(REG_INNER_DIM, inner);
		cfg_put(REG_COLS_B, cols);
		cfg_put(REG_BLOCK_SIZE, bsize);
		cfg_put(REG_PRODUCT_MODE, {2'($urandom), mode});
		cfg_put(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 4'($urandom));
		cfg_we <= 1'b0;
		@(posedge clk);
		n_settings++;
	endtask

	// fill every operand entry the current shape reads before computing
	task automatic send_compute();
		int nr, nk, nc, i, k;
		nr = eff_dim(cfg_rows);
		nk = eff_dim(cfg_inner);
		nc = eff_dim(cfg_cols);
		for (i = 0; i < nr; i++)
			for (k = 0; k < nk; k++)
				if (!a_written[i*MAX_DIM_DEF + k])
					send_item(ACT_LOAD_A, 3'(i), 3'(k), rand_elem());
		for (k = 0; k < nk; k++)
			for (i = 0; i < nc; i++)
				if (!b_written[k*MAX_DIM_DEF + i])
					send_item(ACT_LOAD_B, 3'(k), 3'(i), rand_elem());
		send_item(ACT_COMPUTE, 3'($urandom), 3'($urandom), $urandom);
	endtask

	task automatic random_phase();
		int nr, nk, nc, n, sel;
		logic [1:0] act;
		write_config(pick_dim(), pick_dim(), pick_dim(), pick_dim(), 2'($urandom_range(0, 3)));
		nr = eff_dim(cfg_rows);
		nk = eff_dim(cfg_inner);
		nc = eff_dim(cfg_cols);
		n = $urandom_range(3, 12);
		repeat (n) begin
			sel = $urandom_range(0, 19);
			act = $urandom_range(0, 1) ? ACT_LOAD_B : ACT_LOAD_A;
			if (sel < 16) begin
				if (act == ACT_LOAD_A)
					send_item(act, 3'($urandom_range(0, nr - 1)), 3'($urandom_range(0, nk - 1)),
						rand_elem());
				else
					send_item(act, 3'($urandom_range(0, nk - 1)), 3'($urandom_range(0, nc - 1)),
						rand_elem());
			end else if (sel < 18) begin
				send_item(act, 3'($urandom), 3'($urandom), rand_elem());
			end else if (sel == 18) begin
				send_item(ACT_UNUSED, 3'($urandom), 3'($urandom), $urandom);
			end else begin
				send_compute();
			end
		end
		send_compute();
		wait_drained();
	endtask

	task automatic test_reset_config();
		send_item(ACT_LOAD_A, 3'd0, 3'd0, 32'h7FFFFFFF);
		send_item(ACT_LOAD_A, 3'd7, 3'd7, 32'h80000000);
		send_item(ACT_LOAD_B, 3'd0, 3'd0, 32'h7FFFFFFF);
		send_item(ACT_LOAD_B, 3'd7, 3'd7, 32'h80000000);
		send_item(ACT_LOAD_A, 3'd0, 3'd7, '0);
		send_item(ACT_LOAD_B, 3'd7, 3'd0, 32'd1);
		send_compute();
		wait_drained();
	endtask

	task automatic test_rounding_saturation();
		logic [ELEM_W-1:0] a_vals [6];
		logic [ELEM_W-1:0] b_vals [6];
		int n;
		// overflow both ways, half-LSB rounding up and toward zero from below, exact max
		a_vals = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h00000001, 32'hFFFFFFFF,
			32'h00010000};
		b_vals = '{32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h00008000, 32'h00008000,
			32'h7FFFFFFF};
		write_config('0, '0, '0, '0, MODE_FULL);
		for (n = 0; n < 6; n++) begin
			send_item(ACT_LOAD_A, 3'd0, 3'd0, a_vals[n]);
			send_item(ACT_LOAD_B, 3'd0, 3'd0, b_vals[n]);
			send_compute();
		end
		wait_drained();
	endtask

	task automatic test_product_modes();
		logic [DIM_W-1:0] shapes [3][4];
		int s, m;
		// uneven blocks, block start past the inner dimension, out-of-range sizes
		shapes = '{'{4'd5, 4'd7, 4'd6, 4'd3}, '{4'd8, 4'd3, 4'd8, 4'd5},
			'{4'd15, 4'd9, 4'd12, 4'd0}};
		for (s = 0; s < 3; s++) begin
			for (m = 0; m < 4; m++) begin
				write_config(shapes[s][0], shapes[s][1], shapes[s][2], shapes[s][3], 2'(m));
				send_compute();
				wait_drained();
			end
		end
		write_config(4'd8, 4'd8, 4'd8, 4'd15, MODE_BOTH);
		send_compute();
		wait_drained();
	endtask

	task automatic test_load_bounds();
		write_config(4'd3, 4'd2, 4'd4, 4'd1, MODE_FULL);
		send_item(ACT_LOAD_A, 3'd3, 3'd0, 32'h12345678);
		send_item(ACT_LOAD_A, 3'd0, 3'd2, 32'h12345678);
		send_item(ACT_LOAD_B, 3'd2, 3'd0, 32'h12345678);
		send_item(ACT_LOAD_B, 3'd0, 3'd4, 32'h12345678);
		send_item(ACT_LOAD_A, 3'd2, 3'd1, 32'h00020000);
		send_item(ACT_LOAD_B, 3'd1, 3'd3, 32'hFFFF0000);
		send_item(ACT_UNUSED, 3'd7, 3'd7, 32'hFFFFFFFF);
		send_compute();
		wait_drained();
		// earlier ignored loads must not show up in a wider shape
		write_config(4'd8, 4'd8, 4'd8, 4'd2, MODE_A_BLK);
		send_compute();
		wait_drained();
	endtask

	task automatic test_result_backpressure();
		write_config(4'd8, 4'd8, 4'd8, 4'd3, MODE_B_BLK);
		hold_request = HOLD_CYCLES;
		send_compute();
		repeat (12)
			send_item(ACT_LOAD_A, 3'($urandom), 3'($urandom), rand_elem());
		send_compute();
		wait_drained();
	endtask

	task automatic test_random_traffic();
		int start;
		start = effective_items;
		while (effective_items - start < RANDOM_ITEMS)
			random_phase();
	endtask

	task automatic test_steady_stream();
		int start;
		idle_en = 1'b0;
		start = effective_items;
		while (effective_items - start < STEADY_ITEMS)
			random_phase();
	endtask

	// result side stall: random bursts while idle_en is set, plus a long hold-off when a test requests one
	initial begin : result_pacing
		int burst, hold;
		burst = 0;
		hold = 0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold = hold_request;
				hold_request = 0;
			end
			if (hold > 0) begin
				hold--;
				result_stall <= 1'b1;
			end else if (burst > 0) begin
				burst--;
				result_stall <= 1'b1;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 4) - 1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		c_elem_t exp_e;
		if (arst_n && result_valid && !result_stall) begin
			n_results++;
			if (product_q.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result row %0d col %0d value %h sat %0b last %0b",
					$time, out_row, out_col, out_value, saturated, last);
			end else begin
				exp_e = product_q.pop_front();
				if (out_row !== exp_e.row || out_col !== exp_e.col ||
						out_value !== exp_e.value || saturated !== exp_e.sat ||
						last !== exp_e.last) begin
					mismatches++;
					$display("%0t: result mismatch, expected row %0d col %0d value %h sat %0b last %0b",
						$time, exp_e.row, exp_e.col, exp_e.value, exp_e.sat, exp_e.last);
					$display("%0t:                  actual row %0d col %0d value %h sat %0b last %0b",
						$time, out_row, out_col, out_value, saturated, last);
				end
			end
		end
	end

	initial begin : watchdog
		int stuck;
		stuck = 0;
		while (stuck < STUCK_LIMIT) begin
			@(posedge clk);
			if (!arst_n || cfg_we || (item_valid && !item_stall) ||
					(result_valid && !result_stall))
				stuck = 0;
			else
				stuck++;
		end
		$display("%0t: no request moved for %0d cycles", $time, STUCK_LIMIT);
		$display("FAIL");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_config();
		test_rounding_saturation();
		test_product_modes();
		test_load_bounds();
		test_result_backpressure();
		test_random_traffic();
		test_steady_stream();
		wait_drained();
		$display("covered %0d loads, %0d computes, %0d results over %0d register settings",
			n_loads, n_computes, n_results, n_settings);
		$display("all four product modes, clamped shapes and block sizes, saturation, stalls");
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+src
src/bmm_pkg.sv
src/bmm_ram.sv
src/bmm_front.sv
src/bmm_fifo.sv
src/bmm_back.sv
src/block_diagonal_matrix_multiply.sv
sim/tb.sv
